[sv/tlt_pkg.sv]
// Package for the track lifecycle tracker: word types, lifecycle and sequencer
// codes, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package tlt_pkg;

  // Lifecycle codes as reported in track_state
  typedef enum logic [2:0] {
    LC_PROV = 3'd0,
    LC_CONF = 3'd1,
    LC_PRED = 3'd2,
    LC_OCCL = 3'd3,
    LC_LOST = 3'd4,
    LC_RET  = 3'd5
  } lifecycle_e;

  // Input operation codes
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_OBS   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Sequencer states
  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_AGE,
    FSM_EVAL,
    FSM_VDIV,
    FSM_OBSUPD,
    FSM_XTRP,
    FSM_XUPD,
    FSM_EMIT
  } tlt_fsm_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CONFIRM  = 3'd0,
    CFG_PREDICT  = 3'd1,
    CFG_OCCLUDE  = 3'd2,
    CFG_RETIRE   = 3'd3,
    CFG_MAXPRED  = 3'd4,
    CFG_UNUSED_5 = 3'd5,
    CFG_UNUSED_6 = 3'd6,
    CFG_UNUSED_7 = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [62:0]        time_ns;
    logic signed [15:0] obs_x;
    logic signed [15:0] obs_y;
    logic [15:0]        obs_radius;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         track_state;
    logic signed [15:0] est_x;
    logic signed [15:0] est_y;
    logic [15:0]        est_radius;
    logic [19:0]        uncertainty;
    logic               velocity_valid;
    logic [7:0]         obs_total;
    logic [62:0]        age_ns;
  } out_item_t;

  // Time thresholds are held in ns: at most 65535 ms, below 2^36 ns
  localparam int unsigned THR_W    = 36;
  localparam logic [35:0] NS_PER_MS = 36'd1000000;

  // Quotient width of the velocity divide: 17-bit magnitude scaled by 2^32
  localparam int unsigned VQ_W  = 49;
  localparam int unsigned VEL_W = 50;

  // Serial step counts
  localparam logic [5:0] VDIV_LAST = 6'd48;
  localparam logic [5:0] XTRP_LAST = 6'd39;

  // Misses after which a provisional track retires
  localparam logic [1:0] PROV_MISS_LIMIT = 2'd2;

  // Largest product whose scaled-down value does not exceed the 0x20000 clamp
  localparam logic [51:0] XM_LIMIT = 52'h2_0000_FFFF_FFFF;
  localparam logic [17:0] XM_CLAMP = 18'h20000;

  // Uncertainty divisors: ns per px; the quotient of 16 t counts 1/16 px
  localparam logic [20:0] UDIV_SLOW = 21'd1000000;
  localparam logic [20:0] UDIV_FAST = 21'd2000000;

  // Reset values of the registers
  localparam logic [7:0]  RST_CONFIRM = 8'd3;
  localparam logic [35:0] RST_PREDICT = 36'd100000000;
  localparam logic [35:0] RST_OCCLUDE = 36'd500000000;
  localparam logic [35:0] RST_RETIRE  = 36'd2000000000;
  localparam logic [35:0] RST_MAXPRED = 36'd300000000;

endpackage

`default_nettype wire

[sv/track_lifecycle_tracker_unit.sv]
// Track lifecycle tracker top level: sequencer, track state and output word.
// Sequence: accept, age, evaluate, then emit for start, ignored and plain ticks;
// an observation with a positive time step runs a 49-step divide before its update,
// and a coasting tick with positive extrapolation time runs 40 steps before its update.
// One word in flight: the next is taken once the result is registered and no stall holds it.
// Reset clears the track to Retired and loads the register defaults.
`default_nettype none

module track_lifecycle_tracker_unit import tlt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  tlt_fsm_e fsm_q, fsm_d;
  logic [5:0] cnt_q;

  // configuration
  logic [7:0]       confirm_q;
  logic [THR_W-1:0] pred_thr_q, occl_thr_q, ret_thr_q, maxp_q;

  // track state
  lifecycle_e         life_q;
  logic [7:0]         obs_count_q;
  logic [1:0]         miss_q;
  logic signed [15:0] pos_now_q  [2];
  logic signed [15:0] pos_last_q [2];
  logic [15:0]        radius_q;
  logic [62:0]        last_time_q;
  logic [VEL_W-1:0]   vel_q [2];
  logic               vel_valid_q;
  logic [19:0]        uncert_q;

  // item in work
  in_item_t    item_q;
  logic [63:0] age_q;
  logic        dt_pos_q;
  logic [1:0]  dneg_q;

  // output word
  logic      out_valid_q;
  out_item_t out_q;

  logic accept;
  logic vd_load, vd_step, xm_load, xm_step;

  // evaluation terms
  logic signed [63:0] age_s;
  lifecycle_e         lc_tick;
  logic [63:0]        cap64, t64;
  logic               t_pos, do_pred, dt_pos;
  logic signed [16:0] d_ax [2];
  logic [16:0]        dmag [2];
  logic [48:0]        vmag [2];
  logic [VEL_W-1:0]   vabs [2];
  logic [VQ_W-1:0]    vq [2];
  logic [17:0]        xq [2];
  logic [19:0]        uq;
  logic [7:0]         ncount;
  logic [1:0]         nmiss;
  logic signed [18:0] xsum [2];
  logic signed [15:0] xsat [2];
  logic signed [15:0] obs_ax [2];
  logic [63:0]        age_out;

  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Capture register writes, times scaled to ns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q  <= RST_CONFIRM;
      pred_thr_q <= RST_PREDICT;
      occl_thr_q <= RST_OCCLUDE;
      ret_thr_q  <= RST_RETIRE;
      maxp_q     <= RST_MAXPRED;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CONFIRM: confirm_q  <= cfg_data_i[7:0];
        CFG_PREDICT: pred_thr_q <= 36'(36'(cfg_data_i) * NS_PER_MS);
        CFG_OCCLUDE: occl_thr_q <= 36'(36'(cfg_data_i) * NS_PER_MS);
        CFG_RETIRE:  ret_thr_q  <= 36'(36'(cfg_data_i) * NS_PER_MS);
        CFG_MAXPRED: maxp_q     <= 36'(36'(cfg_data_i) * NS_PER_MS);
        default: ;
      endcase
    end
  end

  // Evaluate the step from the registered age
  always_comb begin
    age_s  = $signed(age_q);
    dt_pos = age_s > 64'sd0;
    cap64  = {28'd0, maxp_q};
    t64    = (age_s < $signed(cap64)) ? age_q : cap64;
    t_pos  = $signed(t64) > 64'sd0;

    // decay cascade
    lc_tick = life_q;
    if (lc_tick == LC_CONF) lc_tick = LC_PRED;
    if (lc_tick == LC_PRED && age_s >= $signed({28'd0, pred_thr_q})) lc_tick = LC_OCCL;
    if (lc_tick == LC_OCCL && age_s >= $signed({28'd0, occl_thr_q})) lc_tick = LC_LOST;
    if (lc_tick == LC_LOST && age_s >= $signed({28'd0, ret_thr_q}))  lc_tick = LC_RET;
    do_pred = (lc_tick == LC_PRED || lc_tick == LC_OCCL) && t_pos;

    obs_ax[0] = item_q.obs_x;
    obs_ax[1] = item_q.obs_y;
    for (int i = 0; i < 2; i++) begin
      d_ax[i] = 17'(obs_ax[i]) - 17'(pos_last_q[i]);
      dmag[i] = d_ax[i][16] ? 17'(-d_ax[i]) : d_ax[i];
      vabs[i] = vel_q[i][VEL_W-1] ? VEL_W'(-vel_q[i]) : vel_q[i];
      vmag[i] = vabs[i][48:0];
      xsum[i] = 19'(pos_last_q[i]) + (vel_q[i][VEL_W-1] ? -$signed({1'b0, xq[i]})
                                                         : $signed({1'b0, xq[i]}));
      xsat[i] = (xsum[i] > 19'sd32767) ? 16'sh7FFF :
                (xsum[i] < -19'sd32768) ? -16'sh8000 : xsum[i][15:0];
    end

    ncount = (obs_count_q == 8'hFF) ? obs_count_q : 8'(obs_count_q + 8'd1);
    nmiss  = (miss_q == 2'd3) ? miss_q : 2'(miss_q + 2'd1);
  end

  // Divider and multiplier lanes
  for (genvar g = 0; g < 2; g++) begin : g_lane
    tlt_vdiv u_vdiv (
      .clk_i     (clk_i),
      .load_i    (vd_load),
      .step_i    (vd_step),
      .mag_i     (dmag[g]),
      .divisor_i (age_q[62:0]),
      .quot_o    (vq[g])
    );
    tlt_xmul u_xmul (
      .clk_i  (clk_i),
      .load_i (xm_load),
      .step_i (xm_step),
      .mag_i  (vmag[g]),
      .t_i    (t64[35:0]),
      .q_o    (xq[g])
    );
  end

  tlt_udiv u_udiv (
    .clk_i  (clk_i),
    .load_i (xm_load),
    .step_i (xm_step),
    .t_i    (t64[35:0]),
    .fast_i (vel_valid_q),
    .u_o    (uq)
  );

  // Next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      FSM_IDLE: if (accept) fsm_d = FSM_AGE;
      FSM_AGE:  fsm_d = FSM_EVAL;
      FSM_EVAL: begin
        unique case (func_e'(item_q.func))
          FUNC_OBS: begin
            if (life_q == LC_LOST || life_q == LC_RET) fsm_d = FSM_EMIT;
            else if (dt_pos) fsm_d = FSM_VDIV;
            else fsm_d = FSM_OBSUPD;
          end
          FUNC_TICK: begin
            if (life_q == LC_RET || life_q == LC_PROV) fsm_d = FSM_EMIT;
            else if (do_pred) fsm_d = FSM_XTRP;
            else fsm_d = FSM_EMIT;
          end
          default: fsm_d = FSM_EMIT;
        endcase
      end
      FSM_VDIV:   if (cnt_q == '0) fsm_d = FSM_OBSUPD;
      FSM_OBSUPD: fsm_d = FSM_EMIT;
      FSM_XTRP:   if (cnt_q == '0) fsm_d = FSM_XUPD;
      FSM_XUPD:   fsm_d = FSM_EMIT;
      FSM_EMIT:   fsm_d = FSM_IDLE;
      default:    fsm_d = FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (fsm_q != FSM_IDLE) || (out_valid_q && out_stall_i);
    vd_load    = fsm_q == FSM_EVAL;
    xm_load    = fsm_q == FSM_EVAL;
    vd_step    = fsm_q == FSM_VDIV;
    xm_step    = fsm_q == FSM_XTRP;
  end

  // Sequencer and step counter: the step count follows the operation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= FSM_IDLE;
      cnt_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      if (fsm_q == FSM_EVAL) begin
        cnt_q <= (func_e'(item_q.func) == FUNC_OBS) ? VDIV_LAST : XTRP_LAST;
      end else if (fsm_q == FSM_VDIV || fsm_q == FSM_XTRP) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // Item capture and age
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (fsm_q == FSM_AGE) age_q <= {1'b0, item_q.time_ns} - {1'b0, last_time_q};
    if (fsm_q == FSM_EVAL) begin
      dt_pos_q <= dt_pos;
      dneg_q   <= {d_ax[1][16], d_ax[0][16]};
    end
  end

  // Track state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q      <= LC_RET;
      obs_count_q <= '0;
      miss_q      <= '0;
      pos_now_q   <= '{default: '0};
      pos_last_q  <= '{default: '0};
      radius_q    <= '0;
      last_time_q <= '0;
      vel_q       <= '{default: '0};
      vel_valid_q <= 1'b0;
      uncert_q    <= '0;
    end else begin
      unique case (fsm_q)
        FSM_EVAL: begin
          if (func_e'(item_q.func) == FUNC_START) begin
            life_q      <= LC_PROV;
            obs_count_q <= 8'd1;
            miss_q      <= '0;
            pos_now_q   <= '{item_q.obs_x, item_q.obs_y};
            pos_last_q  <= '{item_q.obs_x, item_q.obs_y};
            radius_q    <= item_q.obs_radius;
            last_time_q <= item_q.time_ns;
            vel_q       <= '{default: '0};
            vel_valid_q <= 1'b0;
            uncert_q    <= '0;
          end else if (func_e'(item_q.func) == FUNC_TICK && life_q != LC_RET) begin
            if (life_q == LC_PROV) begin
              miss_q <= nmiss;
              if (nmiss >= PROV_MISS_LIMIT) life_q <= LC_RET;
            end else begin
              life_q <= lc_tick;
            end
          end
        end
        FSM_OBSUPD: begin
          if (dt_pos_q) begin
            for (int i = 0; i < 2; i++) begin
              vel_q[i] <= dneg_q[i] ? VEL_W'(-{1'b0, vq[i]}) : {1'b0, vq[i]};
            end
            vel_valid_q <= 1'b1;
          end
          pos_now_q   <= '{item_q.obs_x, item_q.obs_y};
          pos_last_q  <= '{item_q.obs_x, item_q.obs_y};
          obs_count_q <= ncount;
          miss_q      <= '0;
          uncert_q    <= '0;
          radius_q    <= item_q.obs_radius;
          last_time_q <= item_q.time_ns;
          if (life_q == LC_PROV) begin
            if (ncount >= confirm_q) life_q <= LC_CONF;
          end else if (life_q == LC_PRED || life_q == LC_OCCL) begin
            life_q <= LC_CONF;
          end
        end
        FSM_XUPD: begin
          if (vel_valid_q) pos_now_q <= '{xsat[0], xsat[1]};
          uncert_q <= uq;
        end
        default: ;
      endcase
    end
  end

  // Output word
  always_comb begin
    age_out = {1'b0, item_q.time_ns} - {1'b0, last_time_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fsm_q == FSM_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fsm_q == FSM_EMIT) begin
      out_q.track_state    <= life_q;
      out_q.est_x          <= pos_now_q[0];
      out_q.est_y          <= pos_now_q[1];
      out_q.est_radius     <= radius_q;
      out_q.uncertainty    <= uncert_q;
      out_q.velocity_valid <= vel_valid_q;
      out_q.obs_total      <= obs_count_q;
      out_q.age_ns         <= ($signed(age_out) > 64'sd0) ? age_out[62:0] : 63'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the sequencer and track state
  a_accept_to_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> fsm_q == FSM_AGE)
    else $error("accepted word did not start the sequence");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == FSM_EMIT |-> !out_valid_q)
    else $error("result register still full at emit");

  a_prov_misses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    life_q == LC_PROV |-> miss_q < PROV_MISS_LIMIT)
    else $error("provisional track kept past its miss limit");

  a_live_has_obs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    life_q != LC_RET |-> obs_count_q != 8'd0)
    else $error("live track without observations");

  a_vdiv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == FSM_VDIV |-> cnt_q <= VDIV_LAST)
    else $error("divide step count out of range");

endmodule

`default_nettype wire

[sv/tlt_vdiv.sv]
// Velocity divider lane: restoring division, one quotient bit per cycle while stepped.
// Depends on tlt_pkg.
`default_nettype none

module tlt_vdiv import tlt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [16:0]      mag_i,
  input  wire logic [62:0]      divisor_i,
  output logic      [VQ_W-1:0]  quot_o
);

  logic [VQ_W-1:0] dvd_q;
  logic [62:0]     rem_q, rem_d;
  logic [62:0]     div_q;
  logic [VQ_W-1:0] quot_q;
  logic [63:0]     trial;
  logic            ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, dvd_q[VQ_W-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? 63'(trial - {1'b0, div_q}) : trial[62:0];
  end

  // Load operands, then advance one bit per step
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q  <= {mag_i, 32'd0};
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (step_i) begin
      dvd_q  <= {dvd_q[VQ_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[VQ_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

[sv/tlt_xmul.sv]
// Extrapolation multiplier lane: velocity times time, one time bit per cycle while
// stepped, MSB first, with a sticky clamp. Depends on tlt_pkg.
`default_nettype none

module tlt_xmul import tlt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic        step_i,
  input  wire logic [48:0] mag_i,
  input  wire logic [35:0] t_i,
  output logic      [17:0] q_o
);

  logic [48:0] mag_q;
  logic [39:0] t_q;
  logic [49:0] acc_q;
  logic        sat_q;
  logic [51:0] nxt;

  // Double the sum and add the multiplicand where the time bit is set
  always_comb begin
    nxt = {1'b0, acc_q, 1'b0} + (t_q[39] ? {3'd0, mag_q} : 52'd0);
  end

  // Pad the time to the 40-step sequence; hold the clamp once the sum passes
  // the limit, as it only grows
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mag_q <= mag_i;
      t_q   <= {4'd0, t_i};
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (step_i) begin
      t_q <= {t_q[38:0], 1'b0};
      if (!sat_q) begin
        if (nxt > XM_LIMIT) begin
          sat_q <= 1'b1;
        end else begin
          acc_q <= nxt[49:0];
        end
      end
    end
  end

  assign q_o = sat_q ? XM_CLAMP : acc_q[49:32];

endmodule

`default_nettype wire

[sv/tlt_udiv.sv]
// Uncertainty divider: (t * 16) over one of two constant divisors, one quotient bit
// per cycle while stepped, saturated to 20 bits. Depends on tlt_pkg.
`default_nettype none

module tlt_udiv import tlt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic        step_i,
  input  wire logic [35:0] t_i,
  input  wire logic        fast_i,
  output logic      [19:0] u_o
);

  logic [39:0] dvd_q;
  logic [20:0] div_q;
  logic [20:0] rem_q, rem_d;
  logic [39:0] quot_q;
  logic [21:0] trial;
  logic        ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, dvd_q[39]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? 21'(trial - {1'b0, div_q}) : trial[20:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q  <= {t_i, 4'd0};
      div_q  <= fast_i ? UDIV_FAST : UDIV_SLOW;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (step_i) begin
      dvd_q  <= {dvd_q[38:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[38:0], ge};
    end
  end

  // Saturate at 2^20 - 1
  assign u_o = (|quot_q[39:20]) ? 20'hFFFFF : quot_q[19:0];

endmodule

`default_nettype wire

[bench/track_lifecycle_tracker_unit_tb.sv]
// Testbench for the track lifecycle tracker: drives track, observation and tick
// words under varied handshake pressure and checks every result word against a
// built-in lifecycle predictor. Depends on tlt_pkg and track_lifecycle_tracker_unit.
`timescale 1ns / 100ps

module track_lifecycle_tracker_unit_tb;
  import tlt_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 20000;
  localparam int unsigned SETTLE_CYCLES   = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_idx_e  cfg_index;
  logic [15:0] cfg_data;

  track_lifecycle_tracker_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Predictor copy of the registers and the track
  logic [7:0]  thr_confirm;
  logic [15:0] ms_predict, ms_occlude, ms_retire, ms_maxpred;

  lifecycle_e        trk_state;
  logic [7:0]        trk_obs;
  logic [1:0]        trk_miss;
  logic signed [63:0] trk_pos [2];
  logic signed [63:0] trk_anchor [2];
  logic [15:0]       trk_radius;
  logic [62:0]       trk_obs_time;
  logic signed [63:0] trk_vel [2];
  logic              trk_vel_ok;
  logic [19:0]       trk_uncert;

  out_item_t expected_words [$];
  int unsigned n_mismatch;
  int unsigned n_checked;
  int unsigned n_sent;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_receiver;
  bit          timed_out;
  int unsigned lc_seen [6];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [63:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 64'sd32767;
    if (v < -64'sd32768) return -64'sd32768;
    return v;
  endfunction

  function automatic logic signed [63:0] track_age(input logic [62:0] now);
    return $signed({1'b0, now}) - $signed({1'b0, trk_obs_time});
  endfunction

  function automatic void clear_track();
    trk_state = LC_RET;
    trk_obs = '0;
    trk_miss = '0;
    for (int i = 0; i < 2; i++) begin
      trk_pos[i] = 0;
      trk_anchor[i] = 0;
      trk_vel[i] = 0;
    end
    trk_radius = '0;
    trk_obs_time = '0;
    trk_vel_ok = 1'b0;
    trk_uncert = '0;
  endfunction

  // Extrapolate position and grow uncertainty over the capped coast time
  function automatic void coast_track(input logic [62:0] now);
    logic signed [63:0] age, cap, t;
    logic [127:0] prod, q;
    logic [63:0] mag, u;
    age = track_age(now);
    cap = $signed({48'd0, ms_maxpred}) * 64'sd1000000;
    t = (age < cap) ? age : cap;
    if (t <= 0) return;
    if (trk_vel_ok) begin
      for (int i = 0; i < 2; i++) begin
        mag = (trk_vel[i] < 0) ? -trk_vel[i] : trk_vel[i];
        prod = {64'd0, mag} * {64'd0, t};
        q = prod >> 32;
        if (q > 128'h20000) q = 128'h20000;
        trk_pos[i] = sat16(trk_anchor[i] +
                           ((trk_vel[i] < 0) ? -$signed(q[63:0]) : $signed(q[63:0])));
      end
    end
    u = ({1'b0, t[62:0]} << 4) / (trk_vel_ok ? 64'd2000000 : 64'd1000000);
    trk_uncert = (u > 64'hFFFFF) ? 20'hFFFFF : u[19:0];
  endfunction

  function automatic void take_observation(input in_item_t w);
    logic signed [63:0] dt, p, d;
    logic [63:0] mag, q;
    if (trk_state == LC_LOST || trk_state == LC_RET) return;
    dt = track_age(w.time_ns);
    for (int i = 0; i < 2; i++) begin
      p = (i == 0) ? 64'(w.obs_x) : 64'(w.obs_y);
      if (dt > 0) begin
        d = p - trk_anchor[i];
        mag = (d < 0) ? -d : d;
        q = (mag << 32) / dt;
        trk_vel[i] = (d < 0) ? -$signed(q) : $signed(q);
      end
      trk_pos[i] = p;
      trk_anchor[i] = p;
    end
    if (dt > 0) trk_vel_ok = 1'b1;
    if (trk_obs < 8'd255) trk_obs++;
    trk_miss = '0;
    trk_uncert = '0;
    trk_radius = w.obs_radius;
    trk_obs_time = w.time_ns;
  endfunction

  function automatic void advance_lifecycle(input bit seen, input logic [62:0] now);
    logic signed [63:0] age;
    if (trk_state == LC_RET) return;
    if (seen) begin
      if (trk_state == LC_PROV) begin
        if (trk_obs >= thr_confirm) trk_state = LC_CONF;
      end else if (trk_state == LC_PRED || trk_state == LC_OCCL) begin
        trk_state = LC_CONF;
      end
      return;
    end
    age = track_age(now);
    if (trk_state == LC_PROV) begin
      if (trk_miss < 2'd3) trk_miss++;
      if (trk_miss >= PROV_MISS_LIMIT) trk_state = LC_RET;
      return;
    end
    if (trk_state == LC_CONF) trk_state = LC_PRED;
    if (trk_state == LC_PRED && age >= $signed({48'd0, ms_predict}) * 64'sd1000000)
      trk_state = LC_OCCL;
    if (trk_state == LC_OCCL && age >= $signed({48'd0, ms_occlude}) * 64'sd1000000)
      trk_state = LC_LOST;
    if (trk_state == LC_LOST && age >= $signed({48'd0, ms_retire}) * 64'sd1000000)
      trk_state = LC_RET;
    if (trk_state == LC_PRED || trk_state == LC_OCCL) coast_track(now);
  endfunction

  // Work out the result word that one accepted input word causes
  function automatic out_item_t predict_track_word(input in_item_t w);
    out_item_t r;
    logic signed [63:0] age;
    case (func_e'(w.func))
      FUNC_START: begin
        clear_track();
        trk_state = LC_PROV;
        trk_obs = 8'd1;
        trk_pos[0] = 64'(w.obs_x);
        trk_pos[1] = 64'(w.obs_y);
        trk_anchor[0] = trk_pos[0];
        trk_anchor[1] = trk_pos[1];
        trk_radius = w.obs_radius;
        trk_obs_time = w.time_ns;
      end
      FUNC_OBS: begin
        take_observation(w);
        advance_lifecycle(1'b1, w.time_ns);
      end
      FUNC_TICK: advance_lifecycle(1'b0, w.time_ns);
      default: ;
    endcase
    age = track_age(w.time_ns);
    r.track_state    = trk_state;
    r.est_x          = trk_pos[0][15:0];
    r.est_y          = trk_pos[1][15:0];
    r.est_radius     = trk_radius;
    r.uncertainty    = trk_uncert;
    r.velocity_valid = trk_vel_ok;
    r.obs_total      = trk_obs;
    r.age_ns         = (age > 0) ? age[62:0] : '0;
    return r;
  endfunction

  // Send one word: drop valid while idling, offer at the falling edge and hold
  // until accepted; valid stays up for the next word unless a pause follows
  task automatic send_word(input in_item_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_words.push_back(predict_track_word(w));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CONFIRM: thr_confirm = val[7:0];
      CFG_PREDICT: ms_predict  = val;
      CFG_OCCLUDE: ms_occlude  = val;
      CFG_RETIRE:  ms_retire   = val;
      CFG_MAXPRED: ms_maxpred  = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] c, input logic [15:0] p,
                               input logic [15:0] o, input logic [15:0] r,
                               input logic [15:0] m);
    wait_drained();
    write_register(CFG_CONFIRM, c);
    write_register(CFG_PREDICT, p);
    write_register(CFG_OCCLUDE, o);
    write_register(CFG_RETIRE, r);
    write_register(CFG_MAXPRED, m);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_word(input func_e f, input logic [62:0] t,
                                         input logic [15:0] x, input logic [15:0] y,
                                         input logic [15:0] rad);
    in_item_t w;
    w.func = f;
    w.time_ns = t;
    w.obs_x = x;
    w.obs_y = y;
    w.obs_radius = rad;
    return w;
  endfunction

  // Time base of the random part, kept near the track's last observation
  logic [62:0] clock_ns;

  function automatic logic [62:0] step_time();
    case ($urandom_range(9))
      0:       return clock_ns - 63'($urandom_range(5000000));
      1:       return clock_ns;
      2, 3:    return clock_ns + 63'($urandom_range(2000000000)) * 2;
      4:       return clock_ns + 63'($urandom_range(50000));
      default: return clock_ns + 63'($urandom_range(80000000));
    endcase
  endfunction

  function automatic in_item_t random_word(input func_e f);
    in_item_t w;
    w = make_word(f, step_time(), 16'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(3) == 0) begin
      w.obs_x = 16'($signed(trk_anchor[0][15:0]) + $signed(16'($urandom_range(64))) - 32);
      w.obs_y = 16'($signed(trk_anchor[1][15:0]) + $signed(16'($urandom_range(64))) - 32);
    end
    if ($urandom_range(49) == 0) w.time_ns = 63'({$urandom, $urandom});
    return w;
  endfunction

  // Lifetimes: start, a run of observations, then mostly ticks among other words
  task automatic run_lifetimes(input int unsigned n_words);
    int unsigned stop;
    func_e f;
    in_item_t w;
    stop = n_sent + n_words;
    while (n_sent < stop) begin
      clock_ns = 63'({$urandom_range(1000), $urandom});
      send_word(random_word(FUNC_START));
      clock_ns = in_data.time_ns;
      repeat ($urandom_range(6)) begin
        w = random_word(FUNC_OBS);
        send_word(w);
        clock_ns = w.time_ns;
      end
      repeat ($urandom_range(8)) begin
        case ($urandom_range(19))
          0:       f = FUNC_NOP;
          1:       f = FUNC_START;
          2, 3:    f = FUNC_OBS;
          default: f = FUNC_TICK;
        endcase
        w = random_word(f);
        send_word(w);
        if (f != FUNC_TICK) clock_ns = w.time_ns;
      end
    end
  endtask

  task automatic test_directed();
    send_word(make_word(FUNC_TICK, 63'd1000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_OBS, 63'd2000, 16'h10, 16'h10, 16'h5));
    send_word(make_word(FUNC_NOP, 63'd3000, 16'h1, 16'h1, 16'h1));
    send_word(make_word(FUNC_START, 63'd1000000, 16'h7FFF, 16'h8000, 16'hFFFF));
    send_word(make_word(FUNC_OBS, 63'd1000000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_OBS, 63'd500000, 16'h8000, 16'h7FFF, 16'h1234));
    send_word(make_word(FUNC_OBS, 63'd2000000, 16'h7FFF, 16'h8000, 16'h1));
    send_word(make_word(FUNC_OBS, 63'd2000001, 16'h8000, 16'h7FFF, 16'h2));
    send_word(make_word(FUNC_TICK, 63'd1000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_TICK, 63'd60000000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_TICK, 63'd200000000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_OBS, 63'd250000000, 16'h40, 16'hFFC0, 16'h20));
    send_word(make_word(FUNC_TICK, 63'd900000000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_OBS, 63'd950000000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_TICK, 63'h7FFF_FFFF_FFFF_FFFF, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_TICK, 63'h7FFF_FFFF_FFFF_FFFF, 16'h0, 16'h0, 16'h0));
    // Provisional track that misses twice retires
    send_word(make_word(FUNC_START, 63'h7FFF_FFFF_FFFF_FFF0, 16'h5555, 16'hAAAA, 16'h5555));
    send_word(make_word(FUNC_TICK, 63'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(FUNC_TICK, 63'd5, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_OBS, 63'd10, 16'h0, 16'h0, 16'h0));
  endtask

  task automatic test_confirm_zero_and_extremes();
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(make_word(FUNC_START, 63'd100, 16'h10, 16'h20, 16'h30));
    send_word(make_word(FUNC_OBS, 63'd100, 16'h10, 16'h20, 16'h30));
    send_word(make_word(FUNC_TICK, 63'd200, 16'h0, 16'h0, 16'h0));
    load_settings(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(make_word(FUNC_START, 63'd0, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_OBS, 63'd1, 16'h7FFF, 16'h8000, 16'h1));
    send_word(make_word(FUNC_TICK, 63'd70000000000, 16'h0, 16'h0, 16'h0));
    send_word(make_word(FUNC_TICK, 63'd1000, 16'h0, 16'h0, 16'h0));
    run_lifetimes(60);
  endtask

  task automatic test_random_phases();
    load_settings(16'd3, 16'd100, 16'd500, 16'd2000, 16'd300);
    send_idle_pct = 0;  recv_stall_pct = 0;  run_lifetimes(220);
    load_settings(16'd1, 16'd20, 16'd60, 16'd150, 16'd40);
    send_idle_pct = 84; recv_stall_pct = 0;  run_lifetimes(200);
    load_settings(16'd5, 16'd1, 16'd3, 16'd7, 16'd65535);
    send_idle_pct = 0;  recv_stall_pct = 84; run_lifetimes(200);
    load_settings(16'd2, 16'd200, 16'd900, 16'd4000, 16'd1);
    send_idle_pct = 37; recv_stall_pct = 37; run_lifetimes(200);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_receiver = 1'b1;
    run_lifetimes(20);
    hold_receiver = 1'b0;
    wait_drained();
    run_lifetimes(30);
  endtask

  // Receiver stall pattern; a long hold-off counted in cycles when requested
  initial begin
    int unsigned held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
        for (held = 0; held < 400; held++) @(negedge clk);
        out_stall <= 1'b0;
        while (hold_receiver) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result word %p", out_data);
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        lc_seen[want.track_state]++;
        if (out_data !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CONFIRM;
    cfg_data = '0;
    hold_receiver = 1'b0;
    timed_out = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_mismatch = 0;
    n_checked = 0;
    n_sent = 0;
    idle_cycles = 0;
    thr_confirm = 8'd3;
    ms_predict = 16'd100;
    ms_occlude = 16'd500;
    ms_retire = 16'd2000;
    ms_maxpred = 16'd300;
    clear_track();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_confirm_zero_and_extremes();
    test_random_phases();
    test_back_pressure();
    wait_drained();

    $display("sent %0d words, checked %0d results across several register settings",
             n_sent, n_checked);
    $display("states seen: prov %0d conf %0d pred %0d occl %0d lost %0d ret %0d",
             lc_seen[0], lc_seen[1], lc_seen[2], lc_seen[3], lc_seen[4], lc_seen[5]);
    if (n_mismatch == 0 && expected_words.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
